// ===== src/drnt_pkg.sv =====
// shared types, codes and the tanh knot table for the delta rule neuron trainer
// no dependencies
package drnt_pkg;

  localparam int NUM_INPUTS  = 3;
  localparam int NUM_NEURONS = 3;
  localparam int IDX_W       = 2;
  localparam int WIDX_W      = 4;

  localparam logic [1:0] OP_INFER = 2'd0;
  localparam logic [1:0] OP_TRAIN = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [1:0] CFG_RATE = 2'd0;
  localparam logic [1:0] CFG_GAIN = 2'd1;

  localparam logic [15:0] RATE_RESET = 16'd3277;
  localparam logic [14:0] GAIN_RESET = 15'd4096;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_MAC   = 10'b0000000010,
    ST_GAIN  = 10'b0000000100,
    ST_ACT   = 10'b0000001000,
    ST_SQ    = 10'b0000010000,
    ST_DELTA = 10'b0000100000,
    ST_DLR   = 10'b0001000000,
    ST_DW    = 10'b0010000000,
    ST_WUP   = 10'b0100000000,
    ST_FIN   = 10'b1000000000
  } state_t;

  typedef struct packed {
    state_t           step;
    logic             start;
    logic             load;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  function automatic logic [10:0] tanh_knot(input logic [5:0] k);
    logic [10:0] v;
    case (k)
      6'd0:  v = 11'd0;
      6'd1:  v = 11'd127;
      6'd2:  v = 11'd251;
      6'd3:  v = 11'd367;
      6'd4:  v = 11'd473;
      6'd5:  v = 11'd568;
      6'd6:  v = 11'd650;
      6'd7:  v = 11'd721;
      6'd8:  v = 11'd780;
      6'd9:  v = 11'd829;
      6'd10: v = 11'd869;
      6'd11: v = 11'd901;
      6'd12: v = 11'd927;
      6'd13: v = 11'd948;
      6'd14: v = 11'd964;
      6'd15: v = 11'd977;
      6'd16: v = 11'd987;
      6'd17: v = 11'd995;
      6'd18: v = 11'd1001;
      6'd19: v = 11'd1006;
      6'd20: v = 11'd1010;
      6'd21: v = 11'd1013;
      6'd22: v = 11'd1016;
      6'd23: v = 11'd1018;
      6'd24: v = 11'd1019;
      6'd25: v = 11'd1020;
      6'd26: v = 11'd1021;
      6'd27: v = 11'd1022;
      6'd28: v = 11'd1022;
      6'd29: v = 11'd1023;
      6'd30: v = 11'd1023;
      6'd31: v = 11'd1023;
      default: v = 11'd1024;
    endcase
    return v;
  endfunction

endpackage

// ===== src/drnt_ctrl.sv =====
// sequencer for the trainer: walks neurons and inputs, issues datapath steps
// depends on drnt_pkg
module drnt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  drnt_pkg::status_t  status,
  output drnt_pkg::cmd_t     cmd
);
  import drnt_pkg::*;

  state_t           state, state_next;
  logic [IDX_W-1:0] row, row_next;
  logic [IDX_W-1:0] col, col_next;
  logic             train, train_next;
  logic             accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    row_next   = row;
    col_next   = col;
    train_next = train;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          row_next   = '0;
          col_next   = '0;
          train_next = (op == OP_TRAIN);
          if (op == OP_INFER || op == OP_TRAIN) state_next = ST_MAC;
          else state_next = ST_FIN;
        end
      end
      ST_MAC: begin
        if (col == IDX_W'(NUM_INPUTS - 1)) begin
          col_next   = '0;
          state_next = ST_GAIN;
        end else begin
          col_next = col + 1'b1;
        end
      end
      ST_GAIN: state_next = ST_ACT;
      ST_ACT:  state_next = ST_SQ;
      ST_SQ: begin
        if (train) state_next = ST_DELTA;
        else if (row == IDX_W'(NUM_NEURONS - 1)) state_next = ST_FIN;
        else begin
          row_next   = row + 1'b1;
          state_next = ST_MAC;
        end
      end
      ST_DELTA: state_next = ST_DLR;
      ST_DLR:   state_next = ST_DW;
      ST_DW:    state_next = ST_WUP;
      ST_WUP: begin
        if (col != IDX_W'(NUM_INPUTS - 1)) begin
          col_next   = col + 1'b1;
          state_next = ST_DW;
        end else begin
          col_next = '0;
          if (row == IDX_W'(NUM_NEURONS - 1)) state_next = ST_FIN;
          else begin
            row_next   = row + 1'b1;
            state_next = ST_MAC;
          end
        end
      end
      ST_FIN: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      row   <= '0;
      col   <= '0;
      train <= 1'b0;
    end else begin
      state <= state_next;
      row   <= row_next;
      col   <= col_next;
      train <= train_next;
    end
  end

  always_comb begin
    cmd.step  = state;
    cmd.start = accept;
    cmd.load  = accept && (op == OP_LOAD);
    cmd.row   = row;
    cmd.col   = col;
  end

endmodule

// ===== src/drnt_datapath.sv =====
// weights, config registers, shared multiply steps and the result register
// depends on drnt_pkg
module drnt_datapath (
  input  logic               clk,
  input  logic               rst,
  input  drnt_pkg::cmd_t     cmd,
  output drnt_pkg::status_t  status,
  input  logic signed [15:0] x0,
  input  logic signed [15:0] x1,
  input  logic signed [15:0] x2,
  input  logic signed [11:0] d0,
  input  logic signed [11:0] d1,
  input  logic signed [11:0] d2,
  input  logic [1:0]         weight_row,
  input  logic [1:0]         weight_col,
  input  logic signed [15:0] weight_value,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [11:0] out0,
  output logic signed [11:0] out1,
  output logic signed [11:0] out2,
  output logic [12:0]        sample_error,
  output logic               weight_saturated
);
  import drnt_pkg::*;

  localparam int NW = NUM_NEURONS * NUM_INPUTS;

  logic [15:0]        rate;
  logic [14:0]        gain;
  logic signed [15:0] w  [NW];
  logic signed [15:0] xr [NUM_INPUTS];
  logic signed [11:0] dr [NUM_NEURONS];
  logic signed [11:0] o_r[NUM_NEURONS];
  logic signed [33:0] acc;
  logic [46:0]        gp;
  logic signed [12:0] e;
  logic [20:0]        om;
  logic [25:0]        sq;
  logic signed [16:0] delta;
  logic signed [32:0] dl;
  logic signed [48:0] dwp;
  logic               sat;

  logic [WIDX_W-1:0]  widx;
  logic signed [15:0] w_cur;
  logic signed [15:0] x_cur;
  logic signed [11:0] d_cur;
  logic signed [31:0] prod;
  logic [31:0]        acc_mag;
  logic [46:0]        zsum;
  logic [24:0]        z;
  logic [10:0]        kn0, kn1;
  logic [6:0]         kdiff;
  logic [13:0]        interp;
  logic [10:0]        yv;
  logic signed [11:0] o_new;
  logic signed [25:0] ee;
  logic signed [23:0] osq;
  logic signed [34:0] ep;
  logic [34:0]        ep_mag;
  logic [18:0]        dmag;
  logic signed [33:0] dl_full;
  logic signed [48:0] dwp_full;
  logic [48:0]        dw_mag;
  logic [17:0]        dw_rnd;
  logic signed [19:0] nw;
  logic [26:0]        err_sum;
  logic [15:0]        err_raw;
  logic               load_ok;

  assign status.out_free = !out_valid || !out_stall;

  assign widx  = WIDX_W'(cmd.row) * WIDX_W'(NUM_INPUTS) + WIDX_W'(cmd.col);
  assign w_cur = w[widx];
  assign x_cur = xr[cmd.col];
  assign d_cur = dr[cmd.row];

  assign prod    = w_cur * x_cur;
  assign acc_mag = acc[33] ? 32'(-acc) : acc[31:0];

  // tanh by table with linear interpolation between eighth steps
  assign zsum   = gp + 47'(2097152);
  assign z      = zsum[46:22];
  assign kn0    = tanh_knot({1'b0, z[11:7]});
  assign kn1    = tanh_knot({1'b0, z[11:7]} + 6'd1);
  assign kdiff  = 7'(kn1 - kn0);
  assign interp = 14'(kdiff * z[6:0]) + 14'd64;
  assign yv     = (z[24:12] != '0) ? 11'd1024 : kn0 + 11'(interp[13:7]);
  assign o_new  = acc[33] ? -$signed({1'b0, yv}) : $signed({1'b0, yv});

  assign ee  = e * e;
  assign osq = o_r[cmd.row] * o_r[cmd.row];

  // delta: round half away from zero, shift 16
  assign ep     = e * $signed({1'b0, om});
  assign ep_mag = ep[34] ? 35'(-ep) : 35'(ep);
  assign dmag   = 19'((ep_mag + 35'd32768) >> 16);

  assign dl_full  = delta * $signed({1'b0, rate});
  assign dwp_full = dl * x_cur;

  assign dw_mag = dwp[48] ? 49'(-dwp) : 49'(dwp);
  assign dw_rnd = 18'((dw_mag + 49'(31'h40000000)) >> 31);
  assign nw     = 20'(w_cur) + (dwp[48] ? -$signed({2'b0, dw_rnd}) : $signed({2'b0, dw_rnd}));

  assign err_sum = 27'(sq) + 27'd1024;
  assign err_raw = err_sum[26:11];
  assign load_ok = (weight_row < 2'(NUM_NEURONS)) && (weight_col < 2'(NUM_INPUTS));

  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= RATE_RESET;
      gain <= GAIN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RATE: rate <= cfg_data;
        CFG_GAIN: gain <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NW; k++) w[k] <= '0;
    end else if (cmd.load) begin
      if (load_ok)
        w[WIDX_W'(weight_row) * WIDX_W'(NUM_INPUTS) + WIDX_W'(weight_col)] <= weight_value;
    end else if (cmd.step == ST_WUP) begin
      if (nw > 20'sd32767) w[widx] <= 16'sh7fff;
      else if (nw < -20'sd32768) w[widx] <= 16'sh8000;
      else w[widx] <= nw[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      xr[0] <= x0;
      xr[1] <= x1;
      xr[2] <= x2;
      dr[0] <= d0;
      dr[1] <= d1;
      dr[2] <= d2;
      for (int k = 0; k < NUM_NEURONS; k++) o_r[k] <= '0;
      acc <= '0;
      sq  <= '0;
      sat <= 1'b0;
    end else begin
      unique case (cmd.step)
        ST_MAC:  acc <= acc + 34'(prod);
        ST_GAIN: gp  <= 47'(acc_mag) * 47'(gain);
        ST_ACT: begin
          o_r[cmd.row] <= o_new;
          e            <= 13'(d_cur) - 13'(o_new);
        end
        ST_SQ: begin
          sq  <= sq + 26'(ee);
          om  <= 21'(1048576) - 21'(osq);
          acc <= '0;
        end
        ST_DELTA: delta <= ep[34] ? -$signed(17'(dmag)) : $signed(17'(dmag));
        ST_DLR:   dl    <= 33'(dl_full);
        ST_DW:    dwp   <= dwp_full;
        ST_WUP: begin
          if (nw > 20'sd32767 || nw < -20'sd32768) sat <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step == ST_FIN && status.out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step == ST_FIN && status.out_free) begin
      out0             <= o_r[0];
      out1             <= o_r[1];
      out2             <= o_r[2];
      sample_error     <= (err_raw > 16'd8191) ? 13'd8191 : err_raw[12:0];
      weight_saturated <= sat;
    end
  end

endmodule

// ===== src/delta_rule_neuron_trainer_top.sv =====
// top level of the delta rule neuron trainer: controller plus datapath
// depends on drnt_pkg, drnt_ctrl, drnt_datapath
//
// Three tanh neurons over three Q5.10 inputs, one request at a time. A load or
// no-operation request goes straight to the final step; infer and train step
// in turn through three products per neuron, the gain scaling, table lookup,
// squared error, and for training the delta, the rate scaling and one product
// and weight write per input. The result is written in the final step, which
// is held for as long as an earlier result sits stalled in the output register.
// A new request is accepted while the previous result still waits in the output
// register.
// Config writes are always taken; index 0 is learning rate, 1 is gain.
module delta_rule_neuron_trainer_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic signed [15:0] x0,
  input  logic signed [15:0] x1,
  input  logic signed [15:0] x2,
  input  logic signed [11:0] d0,
  input  logic signed [11:0] d1,
  input  logic signed [11:0] d2,
  input  logic [1:0]         weight_row,
  input  logic [1:0]         weight_col,
  input  logic signed [15:0] weight_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [11:0] out0,
  output logic signed [11:0] out1,
  output logic signed [11:0] out2,
  output logic [12:0]        sample_error,
  output logic               weight_saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import drnt_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  drnt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .status   (status),
    .cmd      (cmd)
  );

  drnt_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .x0               (x0),
    .x1               (x1),
    .x2               (x2),
    .d0               (d0),
    .d1               (d1),
    .d2               (d2),
    .weight_row       (weight_row),
    .weight_col       (weight_col),
    .weight_value     (weight_value),
    .cfg_valid        (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out0             (out0),
    .out1             (out1),
    .out2             (out2),
    .sample_error     (sample_error),
    .weight_saturated (weight_saturated)
  );

endmodule

// ===== src/drnt_checker.sv =====
// port-level checks for the delta rule neuron trainer
// depends on delta_rule_neuron_trainer_top, attached by bind
module drnt_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [11:0] out0,
  input logic signed [11:0] out1,
  input logic signed [11:0] out2
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out0) && $stable(out1) && $stable(out2))
    else $error("stalled result changed");

  // sequencer leaves idle in the cycle after a request is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken with no work cycle");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out0 >= -12'sd1024 && out0 <= 12'sd1024 &&
                  out1 >= -12'sd1024 && out1 <= 12'sd1024 &&
                  out2 >= -12'sd1024 && out2 <= 12'sd1024)
    else $error("neuron output beyond unit range");

endmodule

bind delta_rule_neuron_trainer_top drnt_checker u_drnt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out0      (out0),
  .out1      (out1),
  .out2      (out2)
);

// ===== verif/delta_rule_neuron_trainer_top_tb.sv =====
// self-checking testbench for delta_rule_neuron_trainer_top: random and directed
// requests with their own predictor of weights, outputs, error and update clipping
// depends on drnt_pkg and the delta_rule_neuron_trainer_top rtl
`timescale 1ns / 1ps

module delta_rule_neuron_trainer_top_tb;
  import drnt_pkg::*;

  typedef struct {
    logic [1:0]         op;
    logic signed [15:0] x0, x1, x2;
    logic signed [11:0] d0, d1, d2;
    logic [1:0]         row, col;
    logic signed [15:0] wv;
  } request_t;

  typedef struct {
    logic [11:0] o0, o1, o2;
    logic [12:0] err;
    logic        sat;
  } neuron_result_t;

  localparam int TIMEOUT_CYCLES = 1000000;
  localparam int HOLD_CYCLES    = 400;

  localparam int TANH_PTS [0:32] = '{
    0, 127, 251, 367, 473, 568, 650, 721, 780, 829, 869, 901, 927, 948, 964,
    977, 987, 995, 1001, 1006, 1010, 1013, 1016, 1018, 1019, 1020, 1021, 1022,
    1022, 1023, 1023, 1023, 1024};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         op = OP_NOP;
  logic signed [15:0] x0 = '0, x1 = '0, x2 = '0;
  logic signed [11:0] d0 = '0, d1 = '0, d2 = '0;
  logic [1:0]         weight_row = '0, weight_col = '0;
  logic signed [15:0] weight_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b1;
  logic signed [11:0] out0, out1, out2;
  logic [12:0]        sample_error;
  logic               weight_saturated;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = CFG_RATE;
  logic [15:0]        cfg_data = '0;

  delta_rule_neuron_trainer_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  longint         wts [3][3];
  logic [15:0]    rate_q;
  logic [14:0]    gain_q;

  request_t       pending_reqs[$];
  neuron_result_t expected_results[$];
  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;
  bit             hold_go = 0;
  int             hold_left = 0;
  bit             req_taken = 0;
  int             fail_count = 0;
  int             checked = 0;
  int             trains = 0;
  int             clipped = 0;
  int             cycles = 0;

  function automatic longint round_away(longint v, int s);
    longint m;
    m = ((v < 0 ? -v : v) + (64'sd1 <<< (s - 1))) >>> s;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint tanh_lookup(longint acc);
    longint z, y, a, b;
    int k;
    z = ((acc < 0 ? -acc : acc) * longint'(gain_q) + (64'sd1 <<< 21)) >>> 22;
    if (z >= 4096) begin
      y = 1024;
    end else begin
      k = int'(z >>> 7);
      a = TANH_PTS[k];
      b = TANH_PTS[k + 1];
      y = a + (((b - a) * (z & 127) + 64) >>> 7);
    end
    return acc < 0 ? -y : y;
  endfunction

  // runs one request through the predictor and updates the weights
  function automatic neuron_result_t neuron_step(request_t r);
    neuron_result_t res;
    longint xs [3], ds [3], os [3];
    longint acc, e, sq, delta, nw;
    res = '{default: '0};
    if (r.op == OP_NOP) return res;
    if (r.op == OP_LOAD) begin
      if (r.row < 3 && r.col < 3) wts[r.row][r.col] = r.wv;
      return res;
    end
    xs = '{r.x0, r.x1, r.x2};
    ds = '{r.d0, r.d1, r.d2};
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += wts[i][j] * xs[j];
      os[i] = tanh_lookup(acc);
      e = ds[i] - os[i];
      sq += e * e;
    end
    sq = (sq + 1024) >>> 11;
    res.err = sq > 8191 ? 13'd8191 : 13'(sq);
    if (r.op == OP_TRAIN) begin
      for (int i = 0; i < 3; i++) begin
        e = ds[i] - os[i];
        delta = round_away(e * ((64'sd1 <<< 20) - os[i] * os[i]), 16);
        for (int j = 0; j < 3; j++) begin
          nw = wts[i][j] + round_away(delta * longint'(rate_q) * xs[j], 31);
          if (nw > 32767) begin
            nw = 32767;
            res.sat = 1'b1;
          end else if (nw < -32768) begin
            nw = -32768;
            res.sat = 1'b1;
          end
          wts[i][j] = nw;
        end
      end
    end
    res.o0 = 12'(os[0]);
    res.o1 = 12'(os[1]);
    res.o2 = 12'(os[2]);
    return res;
  endfunction

  // request driver
  always @(negedge clk) begin
    if (!rst && (!in_valid || req_taken)) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        request_t r;
        r = pending_reqs.pop_front();
        in_valid <= 1'b1;
        op <= r.op;
        x0 <= r.x0; x1 <= r.x1; x2 <= r.x2;
        d0 <= r.d0; d1 <= r.d1; d2 <= r.d2;
        weight_row <= r.row; weight_col <= r.col; weight_value <= r.wv;
      end else begin
        in_valid <= 1'b0;
      end
    end
    req_taken = 0;
  end

  // result receiver, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_go) begin
      hold_go = 0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    cycles++;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          neuron_result_t x;
          x = expected_results.pop_front();
          checked++;
          if (out0 !== x.o0) begin
            $error("out0 expected %0d got %0d", $signed(x.o0), out0); fail_count++;
          end
          if (out1 !== x.o1) begin
            $error("out1 expected %0d got %0d", $signed(x.o1), out1); fail_count++;
          end
          if (out2 !== x.o2) begin
            $error("out2 expected %0d got %0d", $signed(x.o2), out2); fail_count++;
          end
          if (sample_error !== x.err) begin
            $error("sample_error expected %0d got %0d", x.err, sample_error); fail_count++;
          end
          if (weight_saturated !== x.sat) begin
            $error("weight_saturated expected %0d got %0d", x.sat, weight_saturated);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        request_t r;
        neuron_result_t p;
        r = '{op, x0, x1, x2, d0, d1, d2, weight_row, weight_col, weight_value};
        req_taken = 1;
        p = neuron_step(r);
        if (r.op == OP_TRAIN) trains++;
        if (p.sat) clipped++;
        expected_results.push_back(p);
      end
    end
  end

  task automatic write_cfg(logic [1:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_RATE) rate_q = data;
    else if (idx == CFG_GAIN) gain_q = data[14:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  function automatic request_t random_req();
    request_t r;
    int pick;
    r.op = OP_INFER;
    r.x0 = 16'($urandom); r.x1 = 16'($urandom); r.x2 = 16'($urandom);
    r.d0 = 12'($urandom); r.d1 = 12'($urandom); r.d2 = 12'($urandom);
    r.row = 2'($urandom); r.col = 2'($urandom); r.wv = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 12) begin
      r.op = OP_LOAD;
      if (pick < 9) r.wv = 16'($urandom_range(4096)) - 16'd2048;
    end else if (pick < 16) begin
      r.op = OP_NOP;
    end else if (pick < 21) begin
      r.op = 2'($urandom);
    end else begin
      // well-formed sample: moderate inputs, targets in the tanh range
      r.op = ($urandom_range(9) < 7) ? OP_TRAIN : OP_INFER;
      r.x0 = 16'($urandom_range(4096)) - 16'd2048;
      r.x1 = 16'($urandom_range(4096)) - 16'd2048;
      r.x2 = ($urandom_range(1)) ? -16'sd1024 : 16'($urandom_range(4096)) - 16'd2048;
      r.d0 = 12'($urandom_range(2048)) - 12'd1024;
      r.d1 = 12'($urandom_range(2048)) - 12'd1024;
      r.d2 = $urandom_range(1) ? 12'sd1024 : -12'sd1024;
    end
    return r;
  endfunction

  function automatic request_t make_req(logic [1:0] o, int a, int b, int c,
                                        int e, int f, int g, int rw, int cl, int v);
    request_t r;
    r.op  = o;
    r.x0  = 16'(a);
    r.x1  = 16'(b);
    r.x2  = 16'(c);
    r.d0  = 12'(e);
    r.d1  = 12'(f);
    r.d2  = 12'(g);
    r.row = 2'(rw);
    r.col = 2'(cl);
    r.wv  = 16'(v);
    return r;
  endfunction

  task automatic run_phase(int sidle, int ridle, int n, bit hold);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    for (int i = 0; i < n; i++) pending_reqs.push_back(random_req());
    if (hold) begin
      // let the block fill while results are held back
      hold_go = 1;
    end
    wait_idle();
  endtask

  initial begin
    foreach (wts[i, j]) wts[i][j] = 0;
    rate_q = RATE_RESET;
    gain_q = GAIN_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_cfg(CFG_RATE, RATE_RESET);
    write_cfg(CFG_GAIN, GAIN_RESET);
    // directed: zero weights, extreme loads, ignored load slots, extremes of samples
    pending_reqs.push_back(make_req(OP_INFER, 32767, -32768, -1024, 1024, -1024, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_NOP, -1, -1, -1, -1, -1, -1, 3, 3, -1));
    pending_reqs.push_back(make_req(OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 32767));
    pending_reqs.push_back(make_req(OP_LOAD, 0, 0, 0, 0, 0, 0, 1, 1, -32768));
    pending_reqs.push_back(make_req(OP_LOAD, 0, 0, 0, 0, 0, 0, 2, 2, 1024));
    pending_reqs.push_back(make_req(OP_LOAD, 0, 0, 0, 0, 0, 0, 3, 0, 5555));
    pending_reqs.push_back(make_req(OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 3, 5555));
    pending_reqs.push_back(make_req(OP_INFER, 32767, 32767, 32767, -2048, 2047, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_INFER, 1, -1, 2, 1024, -1024, 1024, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_TRAIN, 1024, 512, -1024, -1024, 1024, -1024, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_TRAIN, 32767, -32768, 32767, -2048, 2047, -2048,
                                    0, 0, 0));
    pending_reqs.push_back(make_req(OP_TRAIN, -32768, 32767, -32768, 2047, -2048, 2047,
                                    0, 0, 0));
    pending_reqs.push_back(make_req(OP_INFER, 100, 200, 300, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_LOAD, 0, 0, 0, 0, 0, 0, 1, 2, -32768));
    pending_reqs.push_back(make_req(OP_TRAIN, 0, 0, -32768, 1024, 1024, 1024, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_INFER, 0, 0, 0, 2047, -2048, 2047, 0, 0, 0));
    run_phase(23, 84, 560, 0);

    write_cfg(CFG_RATE, 16'hFFFF);
    write_cfg(CFG_GAIN, 16'h7FFF);
    write_cfg(2'd3, 16'h1234);
    run_phase(84, 23, 560, 0);

    write_cfg(CFG_RATE, 16'h0000);
    write_cfg(CFG_GAIN, 16'h0000);
    run_phase(0, 0, 100, 0);

    write_cfg(CFG_RATE, 16'($urandom));
    write_cfg(CFG_GAIN, 16'($urandom_range(16383)));
    run_phase(0, 0, 420, 1);

    repeat (60) @(posedge clk);
    $display("covered %0d results, %0d training samples, %0d with clipped weights",
             checked, trains, clipped);
    $display("rate and gain swept through reset, maximum, zero and random settings");
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      if (expected_results.size() != 0) $error("%0d results never arrived",
                                               expected_results.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/drnt_pkg.sv
src/drnt_ctrl.sv
src/drnt_datapath.sv
src/delta_rule_neuron_trainer_top.sv
src/drnt_checker.sv
verif/delta_rule_neuron_trainer_top_tb.sv
